// ===== src/websocket_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer: assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSDF_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define WSDF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define WSDF_ASSERT_NOW(lbl, pre, post, msg)
`define WSDF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== src/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types and constants for the deframer modules.
// ----------------------------------------------------------------------------
package wsdf_pkg;

	localparam logic [6:0]  LEN16_CODE     = 7'd126;
	localparam logic [6:0]  LEN64_CODE     = 7'd127;
	localparam logic [3:0]  EXT16_BYTES    = 4'd2;
	localparam logic [3:0]  EXT64_BYTES    = 4'd8;
	localparam logic [3:0]  KEY_BYTES      = 4'd4;
	localparam logic [31:0] MAX_LEN_RESET  = 32'd65536;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DISCARD = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER   = 2'd0,
		KIND_PAYLOAD  = 2'd1,
		KIND_OVERSIZE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last_in_buf;
	} rx_item_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic        fin;
		logic [3:0]  opcode;
		logic [63:0] length;
		logic [7:0]  pbyte;
		logic        frame_end;
	} result_t;

endpackage

// ===== src/wsdf_in_stage.sv =====
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received byte; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module wsdf_in_stage import wsdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rx_item_t in_item,
	input  logic     step,
	output logic     valid_s1,
	output rx_item_t item_s1
);

	logic vld_s1;

	assign in_ready = !vld_s1 || step;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== src/wsdf_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer header parser and payload unmasker
// Holds the parse state and the size limit; forms at most one result a byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsdf_parser import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [31:0] cfg_data,
	input  logic        step,
	input  rx_item_t    item,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic        mask_q, mask_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [63:0] idx_q, idx_d;
	logic [31:0] max_q;

	logic [7:0]  b;
	logic [7:0]  kb;
	logic        len_done;
	logic        hdr_done;
	logic        over;
	logic        last;

	assign b = item.data;

	always_comb begin
		case (idx_q[1:0])
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		fin_d     = fin_q;
		op_d      = op_q;
		mask_d    = mask_q;
		len_d     = len_q;
		key_d     = key_q;
		idx_d     = idx_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		last      = 1'b0;
		res.valid = 1'b0;
		res.kind  = KIND_HEADER;
		res.pbyte = 8'd0;
		res.frame_end = 1'b0;

		case (phase_q)
			PH_HDR1: begin
				mask_d = b[7];
				len_d  = '0;
				if (b[6:0] == LEN16_CODE) begin
					cnt_d   = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (b[6:0] == LEN64_CODE) begin
					cnt_d   = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					len_d    = {57'd0, b[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d = {len_q[55:0], b};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == 4'd0) begin
					len_done = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], b};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == 4'd0) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				idx_d = idx_q + 64'd1;
				last  = (idx_d >= len_q);
				if (last) begin
					phase_d = PH_HDR0;
				end
				res.valid     = 1'b1;
				res.kind      = KIND_PAYLOAD;
				res.pbyte     = b ^ kb;
				res.frame_end = last;
			end
			PH_DISCARD: begin
				if (item.last_in_buf) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				fin_d   = b[7];
				op_d    = b[3:0];
				phase_d = PH_HDR1;
			end
		endcase

		if (len_done) begin
			key_d = '0;
			if (mask_d) begin
				cnt_d   = KEY_BYTES;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		over = (len_d[63:32] != 32'd0) || (len_d[31:0] > max_q);

		if (hdr_done) begin
			res.valid = 1'b1;
			if (over) begin
				phase_d       = item.last_in_buf ? PH_HDR0 : PH_DISCARD;
				res.kind      = KIND_OVERSIZE;
				res.frame_end = 1'b1;
			end else if (len_d == 64'd0) begin
				phase_d       = PH_HDR0;
				res.frame_end = 1'b1;
			end else begin
				idx_d   = '0;
				phase_d = PH_PAYLOAD;
			end
		end

		res.fin    = fin_q;
		res.opcode = op_q;
		res.length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			key_q   <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			len_q   <= len_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_q <= cfg_data;
		end
	end

	`WSDF_ASSERT_NOW(a_idx_below_len, phase_q == PH_PAYLOAD, idx_q < len_q, "payload index past length")
	`WSDF_ASSERT_NOW(a_key_cnt_range, phase_q == PH_KEY, (cnt_q != 4'd0) && (cnt_q <= KEY_BYTES), "key byte count out of range")
	`WSDF_ASSERT_NEXT(a_discard_after_over, step && res.valid && (res.kind == KIND_OVERSIZE) && !item.last_in_buf, phase_q == PH_DISCARD, "oversize frame not discarded")

endmodule

// ===== src/wsdf_out_stage.sv =====
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsdf_out_stage import wsdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    slot_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	`WSDF_ASSERT_NOW(a_no_overwrite, load && valid_q, out_ready, "result overwritten before transfer")

endmodule

// ===== src/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into frame headers and unmasked payload.
//
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready     rx_byte, buffer_end
//   out      out  out_valid/out_ready   result_kind .. frame_end
//   cfg      in   cfg_valid/cfg_ready   cfg_data (max_payload_length)
//
// One byte per cycle sustained while out_ready stays high; a byte is held in
// the input register, and its result is formed by the parse logic and loaded
// into the result register, from which it transfers.
// The per-byte state update and unmask fit between those two registers.
// Reset is immediate, no clearing pass; cfg_ready is always high.
// A stalled result stops the parser; the input register then takes one more
// byte only while it is empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic        final_fragment,
	output logic [3:0]  frame_opcode,
	output logic [63:0] payload_length,
	output logic [7:0]  payload_byte,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	rx_item_t in_item;
	rx_item_t item_s1;
	logic     valid_s1;
	logic     step;
	logic     slot_free;
	result_t  res;
	result_t  res_out;

	assign in_item.data        = rx_byte;
	assign in_item.last_in_buf = buffer_end;
	assign step                = valid_s1 && slot_free;
	assign cfg_ready           = 1'b1;

	wsdf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.step     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsdf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.step      (step),
		.item      (item_s1),
		.res       (res)
	);

	wsdf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res.valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign result_kind    = res_out.kind;
	assign final_fragment = res_out.fin;
	assign frame_opcode   = res_out.opcode;
	assign payload_length = res_out.length;
	assign payload_byte   = res_out.pbyte;
	assign frame_end      = res_out.frame_end;

endmodule
